[sv/fba_pkg.sv]
// shared types, constants and codes for the frame bitmap allocator
package fba_pkg;

  // bitmap geometry
  localparam int FRAME_WORDS = 128;
  localparam int WORD_BITS   = 32;
  localparam int WORD_AW     = $clog2(FRAME_WORDS);
  localparam int COUNT_W     = $clog2(FRAME_WORDS + 1);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int FRAME_W     = 12;
  localparam int CFG_W       = 8;
  localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

  // result status codes
  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_MAPPED    = 3'd1,
    ST_NOMEM     = 3'd2,
    ST_FREED     = 3'd3,
    ST_NOTHING   = 3'd4
  } status_t;

  // request opcodes
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // request beat
  typedef struct packed {
    logic               op;
    logic [FRAME_W-1:0] page_frame;
    logic               is_kernel;
    logic               is_writable;
  } req_t;

  // result beat
  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] new_frame;
    logic               present;
    logic               writable;
    logic               user_access;
  } res_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    scan_rd;
    logic    free_rd;
    logic    alloc_wr;
    logic    free_wr;
    logic    res_en;
    status_t res_status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_free;
    logic pf_zero;
    logic hit;
    logic exhausted;
  } stat_t;

endpackage

[sv/fba_ctrl.sv]
// request sequencer for the frame bitmap allocator
module fba_ctrl import fba_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.pf_zero && !stat.is_free) begin
          state_next = S_SCAN;
        end else if (!stat.pf_zero && stat.is_free) begin
          state_next = S_FREE_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.hit || stat.exhausted) begin
          state_next = S_IDLE;
        end
      end
      S_FREE_RD: state_next = S_FREE_WR;
      S_FREE_WR: state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    busy           = (state != S_IDLE);
    cmd            = '0;
    cmd.res_status = ST_ALLOCATED;
    case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DECODE: begin
        if (!stat.is_free && !stat.pf_zero) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_MAPPED;
        end else if (stat.is_free && stat.pf_zero) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_NOTHING;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = !stat.exhausted && !stat.hit;
        if (stat.hit) begin
          cmd.alloc_wr   = 1'b1;
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_ALLOCATED;
        end else if (stat.exhausted) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_NOMEM;
        end
      end
      S_FREE_RD: begin
        cmd.free_rd = 1'b1;
      end
      S_FREE_WR: begin
        cmd.free_wr    = 1'b1;
        cmd.res_en     = 1'b1;
        cmd.res_status = ST_FREED;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[sv/fba_datapath.sv]
// bitmap memory, word scan and result register for the frame allocator
module fba_datapath import fba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  cmd_t             cmd,
  output stat_t            stat,
  output logic             result_valid,
  output res_t             result
);

  // bitmap store, words not yet written read as all free
  logic [WORD_BITS-1:0]   mem [FRAME_WORDS];
  logic [FRAME_WORDS-1:0] word_vld;

  req_t                   cur;
  logic [CFG_W-1:0]       word_count;
  logic [COUNT_W-1:0]     limit;
  logic [COUNT_W-1:0]     scan_addr;
  logic [WORD_AW-1:0]     chk_addr;
  logic                   pend;
  logic [WORD_BITS-1:0]   rd_word;
  logic [WORD_AW-1:0]     rd_addr;
  logic [WORD_AW-1:0]     free_addr;
  logic [BIT_W-1:0]       clr_bit;
  logic [WORD_AW-1:0]     wr_addr;
  logic [WORD_BITS-1:0]   wr_data;
  logic                   wr_en;
  logic                   scan_done;

  // word count register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= CFG_W'(FRAME_WORDS);
    end else if (cfg_wr_en) begin
      word_count <= cfg_wr_data;
    end
  end

  // search limit saturated to the bitmap depth
  always_comb begin
    if (word_count > CFG_W'(FRAME_WORDS)) begin
      limit = COUNT_W'(FRAME_WORDS);
    end else begin
      limit = COUNT_W'(word_count);
    end
  end

  // request capture and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
    if (cmd.scan_rd) begin
      chk_addr <= scan_addr[WORD_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      pend      <= 1'b0;
    end else begin
      pend <= cmd.scan_rd;
      if (cmd.load) begin
        scan_addr <= '0;
      end else if (cmd.scan_rd) begin
        scan_addr <= scan_addr + COUNT_W'(1);
      end
    end
  end

  assign scan_done = (scan_addr >= limit);
  assign free_addr = cur.page_frame[FRAME_W-1:BIT_W];

  // lowest clear bit of the word under check
  always_comb begin
    clr_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_word[i]) begin
        clr_bit = BIT_W'(i);
      end
    end
  end

  // status toward the controller, the scan ends on a hit or once the last searched word misses
  always_comb begin
    stat.is_free   = (cur.op == OP_FREE);
    stat.pf_zero   = (cur.page_frame == '0);
    stat.hit       = pend && (rd_word != FULL_WORD);
    stat.exhausted = scan_done && !(pend && (rd_word != FULL_WORD));
  end

  // memory port selection
  always_comb begin
    rd_addr = cmd.free_rd ? free_addr : scan_addr[WORD_AW-1:0];
    wr_en   = cmd.alloc_wr || cmd.free_wr;
    if (cmd.free_wr) begin
      wr_addr = free_addr;
      wr_data = rd_word & ~(WORD_BITS'(1) << cur.page_frame[BIT_W-1:0]);
    end else begin
      wr_addr = chk_addr;
      wr_data = rd_word | (WORD_BITS'(1) << clr_bit);
    end
  end

  // bitmap write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.scan_rd || cmd.free_rd) begin
      rd_word <= word_vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  // per-word written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      word_vld <= '0;
    end else if (wr_en) begin
      word_vld[wr_addr] <= 1'b1;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.res_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      result.status <= cmd.res_status;
      case (cmd.res_status)
        ST_ALLOCATED: begin
          result.new_frame   <= FRAME_W'({chk_addr, clr_bit});
          result.present     <= 1'b1;
          result.writable    <= cur.is_writable;
          result.user_access <= !cur.is_kernel;
        end
        ST_MAPPED: begin
          result.new_frame   <= cur.page_frame;
          result.present     <= 1'b0;
          result.writable    <= 1'b0;
          result.user_access <= 1'b0;
        end
        default: begin
          result.new_frame   <= '0;
          result.present     <= 1'b0;
          result.writable    <= 1'b0;
          result.user_access <= 1'b0;
        end
      endcase
    end
  end

endmodule

[sv/frame_bitmap_allocator.sv]
// frame bitmap allocator: first-fit page frame allocate and free over a bitmap
// a free reads and then writes back its bitmap word; a mapped or nothing to free request answers
// from decode; an allocate scans the searched words in order, one bitmap word read per cycle.
// throughput: one request at a time; start is taken again in the result beat cycle.
// the result beat shows for one cycle on result_valid; the receiver cannot stall.
// reset: synchronous, the bitmap reads as all free at once and word_count is 128.
module frame_bitmap_allocator import fba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output logic             result_valid,
  output res_t             result
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  fba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // bitmap and result datapath
  fba_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

[sv/fba_checker.sv]
// port-level checks for the frame bitmap allocator, bound to the top level
module fba_checker import fba_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_valid,
  input res_t             result
);

  // an accepted request keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  // no result beat right after a request is taken
  a_no_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_valid)
    else $error("result beat too early after accept");

  // result beats never come back to back
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("back to back result beats");

  // only an allocation carries page flags
  a_flags_alloc_only: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_ALLOCATED) |->
      (!result.present && !result.writable && !result.user_access))
    else $error("page flags set on a non-allocation result");

  // an allocation always marks the page present
  a_alloc_present: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_ALLOCATED) |-> result.present)
    else $error("allocated page not marked present");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);

[tb/frame_bitmap_allocator_test.sv]
// self-checking testbench for the frame bitmap allocator with a bitmap scoreboard
module frame_bitmap_allocator_test;
  import fba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // tracks the frame bitmap and the queue of results it implies
  class frame_scoreboard;
    logic [WORD_BITS-1:0] bitmap [FRAME_WORDS];
    int unsigned          word_count;
    res_t                 pending [$];
    logic [FRAME_W-1:0]   held [$];
    int                   errors;
    int                   status_seen [5];

    function new();
      foreach (bitmap[w]) bitmap[w] = '0;
      foreach (status_seen[s]) status_seen[s] = 0;
      word_count = FRAME_WORDS;
      errors = 0;
    endfunction

    function void write_word_count(logic [CFG_W-1:0] value);
      word_count = value;
    endfunction

    // work out the result beat of one accepted request
    function void note_request(req_t r);
      res_t        e;
      int unsigned limit;
      int unsigned frame;
      int unsigned w;
      bit          found;
      e = '0;
      found = 1'b0;
      frame = 0;
      if (r.op == OP_ALLOC) begin
        if (r.page_frame != '0) begin
          e.status = ST_MAPPED;
          e.new_frame = r.page_frame;
        end else begin
          // first fit over the searched words, count saturates at the bitmap size
          limit = (word_count > FRAME_WORDS) ? FRAME_WORDS : word_count;
          for (int i = 0; i < limit; i++) begin
            if (!found && bitmap[i] != FULL_WORD) begin
              for (int b = 0; b < WORD_BITS; b++) begin
                if (!found && !bitmap[i][b]) begin
                  found = 1'b1;
                  frame = i * WORD_BITS + b;
                end
              end
            end
          end
          if (!found) begin
            e.status = ST_NOMEM;
          end else begin
            bitmap[frame / WORD_BITS][frame % WORD_BITS] = 1'b1;
            e.status = ST_ALLOCATED;
            e.new_frame = frame[FRAME_W-1:0];
            e.present = 1'b1;
            e.writable = r.is_writable;
            e.user_access = ~r.is_kernel;
            held.push_back(frame[FRAME_W-1:0]);
          end
        end
      end else begin
        if (r.page_frame == '0) begin
          e.status = ST_NOTHING;
        end else begin
          w = r.page_frame / WORD_BITS;
          if (w < FRAME_WORDS) bitmap[w][r.page_frame % WORD_BITS] = 1'b0;
          e.status = ST_FREED;
        end
      end
      status_seen[int'(e.status)]++;
      pending.push_back(e);
    endfunction

    // compare one result beat against the oldest expected beat
    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: status %0d frame %0d",
               got.status, got.new_frame);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status);
        errors++;
      end
      if (got.new_frame !== e.new_frame) begin
        $error("new_frame: expected %0d, actual %0d", e.new_frame, got.new_frame);
        errors++;
      end
      if (got.present !== e.present) begin
        $error("present: expected %0b, actual %0b", e.present, got.present);
        errors++;
      end
      if (got.writable !== e.writable) begin
        $error("writable: expected %0b, actual %0b", e.writable, got.writable);
        errors++;
      end
      if (got.user_access !== e.user_access) begin
        $error("user_access: expected %0b, actual %0b", e.user_access, got.user_access);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  req_t             req = '0;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             result_valid;
  res_t             result;

  frame_scoreboard  sb = new();
  int unsigned      taken = 0;
  int unsigned      burst_left = 1;
  int unsigned      settings_used = 0;
  int unsigned      wc_plan [8];

  frame_bitmap_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .result_valid (result_valid),
    .result       (result)
  );

  always #5 clk = ~clk;

  // sample request, config and result beats at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_result(result);
      if (cfg_wr_en) sb.write_word_count(cfg_wr_data);
      if (start && !busy) begin
        sb.note_request(req);
        taken++;
      end
    end
  end

  function automatic req_t make_req(op_t op, logic [FRAME_W-1:0] pf, logic kern, logic wr);
    req_t r;
    r.op = op;
    r.page_frame = pf;
    r.is_kernel = kern;
    r.is_writable = wr;
    return r;
  endfunction

  // mostly real allocations and frees of held frames, some noise
  function automatic req_t pick_request();
    int unsigned        roll;
    int unsigned        idx;
    logic [FRAME_W-1:0] pf;
    logic               kern;
    logic               wr;
    roll = $urandom_range(0, 99);
    kern = 1'($urandom_range(0, 1));
    wr = 1'($urandom_range(0, 1));
    pf = FRAME_W'($urandom_range(0, (1 << FRAME_W) - 1));
    if (roll < 75 && roll >= 45 && sb.held.size() != 0) begin
      idx = $urandom_range(0, sb.held.size() - 1);
      pf = sb.held[idx];
      sb.held.delete(idx);
      return make_req(OP_FREE, pf, kern, wr);
    end
    if (roll < 75) return make_req(OP_ALLOC, '0, kern, wr);
    if (roll < 85) return make_req(OP_ALLOC, pf, kern, wr);
    if (roll < 95) return make_req(OP_FREE, pf, kern, wr);
    if (roll < 97) return make_req(OP_ALLOC, '1, kern, wr);
    return make_req(OP_FREE, '0, kern, wr);
  endfunction

  // hold one request beat until the block takes it
  task automatic issue(input req_t r);
    int unsigned seen;
    seen = taken;
    start <= 1'b1;
    req <= r;
    do @(negedge clk); while (taken == seen);
  endtask

  // sender bursts with random gaps between them
  task automatic pace();
    if (--burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // drop start and wait for every expected beat and for busy to clear
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0 || busy) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_word_count(input logic [CFG_W-1:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: frame zero, mapped, nothing to free, double free, extremes
    issue(make_req(OP_ALLOC, '0, 1'b0, 1'b1));
    issue(make_req(OP_ALLOC, '0, 1'b1, 1'b0));
    issue(make_req(OP_ALLOC, '0, 1'b0, 1'b0));
    issue(make_req(OP_ALLOC, '1, 1'b1, 1'b1));
    issue(make_req(OP_ALLOC, 12'd1, 1'b0, 1'b1));
    issue(make_req(OP_FREE, '0, 1'b1, 1'b1));
    issue(make_req(OP_FREE, 12'd1, 1'b0, 1'b0));
    issue(make_req(OP_FREE, 12'd1, 1'b1, 1'b0));
    issue(make_req(OP_ALLOC, '0, 1'b1, 1'b1));
    issue(make_req(OP_FREE, '1, 1'b0, 1'b1));
    issue(make_req(OP_FREE, 12'hAAA, 1'b1, 1'b0));
    issue(make_req(OP_ALLOC, 12'h555, 1'b0, 1'b1));

    // word count zero searches nothing
    write_word_count(8'd0);
    issue(make_req(OP_ALLOC, '0, 1'b1, 1'b1));
    issue(make_req(OP_FREE, 12'd2, 1'b0, 1'b0));
    issue(make_req(OP_ALLOC, '0, 1'b0, 1'b0));

    // oversized word count saturates
    write_word_count(8'd255);
    issue(make_req(OP_ALLOC, '0, 1'b0, 1'b1));
    issue(make_req(OP_ALLOC, '0, 1'b1, 1'b0));
    issue(make_req(OP_FREE, 12'd3, 1'b1, 1'b1));

    // random phases, small counts to reach out of memory often
    wc_plan = '{1, 128, 2, 0, 255, 3, 64, 128};
    wc_plan[4] = $urandom_range(129, 255);
    wc_plan[5] = $urandom_range(3, 16);
    wc_plan[6] = $urandom_range(1, 128);
    foreach (wc_plan[p]) begin
      write_word_count(wc_plan[p][CFG_W-1:0]);
      burst_left = $urandom_range(1, 30);
      repeat ((wc_plan[p] == 0) ? 40 : 260) begin
        issue(pick_request());
        pace();
      end
    end

    drain();
    repeat (FRAME_WORDS + 8) @(negedge clk);
    $display("covered %0d requests over %0d word count settings", taken, settings_used);
    $display("allocated %0d, mapped %0d, out of memory %0d, freed %0d, nothing to free %0d",
             sb.status_seen[ST_ALLOCATED], sb.status_seen[ST_MAPPED],
             sb.status_seen[ST_NOMEM], sb.status_seen[ST_FREED],
             sb.status_seen[ST_NOTHING]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run time guard
  initial begin
    #20_000_000;
    $display("timeout with %0d beats still expected", sb.pending.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
